>>> rtl/chained_hash_table_macros.svh
// Assertion macros for the hash table RTL.
`ifndef CHAINED_HASH_TABLE_MACROS_SVH
`define CHAINED_HASH_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cht_pkg.sv
// Package: sizes, codes and types of the chained hash table.
package cht_pkg;

    localparam int BUCKETS = 1024;  // power of two: bucket is the low key bits
    localparam int NODES   = 1024;

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int NODE_W  = $clog2(NODES);
    localparam int LINK_W  = $clog2(NODES + 1);
    localparam int KEY_W   = 31;
    localparam int DATA_W  = 32;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_FOUND     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_WALK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic signed [DATA_W-1:0] price;
        logic signed [DATA_W-1:0] quantity;
        logic [LINK_W-1:0]        next;
    } node_t;

endpackage

>>> rtl/cht_if.sv
// Interfaces: request and response channels of the hash table.
interface cht_in_if import cht_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [KEY_W-1:0]         key;
    logic signed [DATA_W-1:0] price;
    logic signed [DATA_W-1:0] quantity;

    modport source (output valid, command, key, price, quantity, input ready);
    modport sink   (input valid, command, key, price, quantity, output ready);
endinterface

interface cht_out_if import cht_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] found_price;
    logic signed [DATA_W-1:0] found_quantity;

    modport source (output valid, status, found_price, found_quantity, input ready);
    modport sink   (input valid, status, found_price, found_quantity, output ready);
endinterface

>>> rtl/chained_hash_table.sv
// Top level: hash table with separate chaining over a fixed node pool.
//
//  channel | dir | payload                                   | transfer
//  --------+-----+-------------------------------------------+------------------
//  req     | in  | command, key, price, quantity             | valid & ready
//  rsp     | out | status, found_price, found_quantity       | valid & ready
//
// Insert: accept with bucket head read, node and head write, response load.
// Lookup: accept with head read, head check, walk, response load; an empty
//   bucket skips the walk. One node read per cycle sets the walk rate.
// After reset the bucket head memory is swept to empty, one bucket a cycle,
//   with req.ready low.
// req.ready is high only between items; a finished result waits in the
//   response state while rsp holds an unaccepted transfer.
`include "chained_hash_table_macros.svh"

module chained_hash_table import cht_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    cht_in_if.sink    req,
    cht_out_if.source rsp
);

    // Sequencer and control state
    state_t             state_reg, state_next;
    logic [BKT_W-1:0]   clr_reg, clr_next;
    logic [LINK_W-1:0]  nodes_used_reg, nodes_used_next;
    logic [LINK_W-1:0]  cur_reg, cur_next;
    logic               out_valid_reg, out_valid_next;

    // Latched item (payload, no reset)
    cmd_t                     cmd_reg;
    logic [KEY_W-1:0]         key_reg;
    logic signed [DATA_W-1:0] price_reg;
    logic signed [DATA_W-1:0] qty_reg;

    // Pending result and output register (payload, no reset)
    status_t                  res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_price_reg, res_price_next;
    logic signed [DATA_W-1:0] res_qty_reg, res_qty_next;
    status_t                  out_status_reg;
    logic signed [DATA_W-1:0] out_price_reg;
    logic signed [DATA_W-1:0] out_qty_reg;

    // Memories
    logic [LINK_W-1:0] head_mem [BUCKETS];
    node_t             node_mem [NODES];
    logic [LINK_W-1:0] head_q;
    node_t             node_q;

    // Memory port controls
    logic              head_we, head_re;
    logic [BKT_W-1:0]  head_waddr, head_raddr;
    logic [LINK_W-1:0] head_wdata;
    logic              node_we, node_re;
    logic [NODE_W-1:0] node_waddr, node_raddr;
    node_t             node_wdata;

    logic              load_item, load_out;
    logic              key_match;
    logic [BKT_W-1:0]  bkt;

    assign bkt       = key_reg[BKT_W-1:0];
    // The compare unit: one node key against the search key per cycle.
    assign key_match = (node_q.key == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        nodes_used_next = nodes_used_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_price_next  = res_price_reg;
        res_qty_next    = res_qty_reg;
        head_we         = 1'b0;
        head_re         = 1'b0;
        head_waddr      = bkt;
        head_raddr      = req.key[BKT_W-1:0];
        head_wdata      = nodes_used_reg;
        node_we         = 1'b0;
        node_re         = 1'b0;
        node_waddr      = nodes_used_reg[NODE_W-1:0];
        node_raddr      = node_q.next[NODE_W-1:0];
        node_wdata.key      = key_reg;
        node_wdata.price    = price_reg;
        node_wdata.quantity = qty_reg;
        node_wdata.next     = head_q;
        req.ready       = 1'b0;
        load_item       = 1'b0;
        load_out        = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = NULL_LINK;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == BKT_W'(BUCKETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    load_item  = 1'b1;
                    head_re    = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                res_price_next = '0;
                res_qty_next   = '0;
                state_next     = ST_RESP;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (nodes_used_reg >= NULL_LINK)
                        res_status_next = STAT_FULL;
                    else
                    begin
                        node_we         = 1'b1;
                        head_we         = 1'b1;
                        nodes_used_next = nodes_used_reg + 1'b1;
                        res_status_next = STAT_INSERTED;
                    end
                end
                else if (head_q >= NULL_LINK)
                    res_status_next = STAT_NOT_FOUND;
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = head_q[NODE_W-1:0];
                    cur_next   = head_q;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (key_match)
                begin
                    res_status_next = STAT_FOUND;
                    res_price_next  = node_q.price;
                    res_qty_next    = node_q.quantity;
                    state_next      = ST_RESP;
                end
                else if (node_q.next >= NULL_LINK)
                begin
                    res_status_next = STAT_NOT_FOUND;
                    res_price_next  = '0;
                    res_qty_next    = '0;
                    state_next      = ST_RESP;
                end
                else
                begin
                    node_re  = 1'b1;
                    cur_next = node_q.next;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            nodes_used_reg <= '0;
            cur_reg        <= NULL_LINK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            nodes_used_reg <= nodes_used_next;
            cur_reg        <= cur_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            cmd_reg   <= cmd_t'(req.command);
            key_reg   <= req.key;
            price_reg <= req.price;
            qty_reg   <= req.quantity;
        end
        res_status_reg <= res_status_next;
        res_price_reg  <= res_price_next;
        res_qty_reg    <= res_qty_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_price_reg  <= res_price_reg;
            out_qty_reg    <= res_qty_reg;
        end
    end

    // Bucket head memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        if (head_re)
            head_q <= head_mem[head_raddr];
    end

    // Node pool memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        if (node_re)
            node_q <= node_mem[node_raddr];
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.found_price    = out_price_reg;
    assign rsp.found_quantity = out_qty_reg;

    // Checks
    `CHT_ASSERT_NOW(a_pool_bound, 1'b1, nodes_used_reg <= NULL_LINK,
        "node count past pool size")
    `CHT_ASSERT_NOW(a_walk_written, state_reg == ST_WALK, cur_reg < nodes_used_reg,
        "walk reached an unallocated node")
    `CHT_ASSERT_NEXT(a_alloc_step,
        state_reg == ST_HEAD && cmd_reg == CMD_INSERT && nodes_used_reg < NULL_LINK,
        nodes_used_reg == $past(nodes_used_reg) + 1'b1,
        "insert did not allocate one node")
    `CHT_ASSERT_NOW(a_found_lookup, $rose(rsp.valid) && rsp.status == STAT_FOUND,
        cmd_reg == CMD_LOOKUP, "found status on an insert")

endmodule

>>> bench/testbench.sv
// Testbench for chained_hash_table: directed table, then random traffic against a predictor.
module testbench import cht_pkg::*; ();

    // Cycles with no transfer on either channel before the run is called hung.
    // The bucket sweep after reset and a walk over the whole
    // pool are the longest quiet stretches.
    localparam int STALL_LIMIT = 8 * (BUCKETS + NODES + 16);
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_DIRECTED = 16;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic signed [DATA_W-1:0] D_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] D_MIN = 32'sh8000_0000;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] price;
        logic signed [DATA_W-1:0] quantity;
    } lookup_rsp_t;

    // One row of the directed table; when fixed is set the response is typed in.
    typedef struct packed {
        cmd_t                     cmd;
        logic [KEY_W-1:0]         key;
        logic signed [DATA_W-1:0] price;
        logic signed [DATA_W-1:0] quantity;
        bit                       fixed;
        lookup_rsp_t              rsp;
    } table_row_t;

    logic clk;
    logic rst_n;

    cht_in_if  req_if ();
    cht_out_if rsp_if ();

    chained_hash_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    // Predictor copy of the table.
    logic [LINK_W-1:0]        shadow_head  [BUCKETS];
    logic [KEY_W-1:0]         shadow_key   [NODES];
    logic signed [DATA_W-1:0] shadow_price [NODES];
    logic signed [DATA_W-1:0] shadow_qty   [NODES];
    logic [LINK_W-1:0]        shadow_next  [NODES];
    int                       shadow_used;

    lookup_rsp_t      expected_rsps [$];
    logic [KEY_W-1:0] stored_keys   [$];   // keys inserted so far, for hits
    int               fail_count;
    bit               idle_on;             // random idling on both channels

    lookup_rsp_t      got_rsp;
    lookup_rsp_t      want_rsp;
    table_row_t       directed_rows [N_DIRECTED];

    function automatic void clear_table();
        for (int b = 0; b < BUCKETS; b++)
            shadow_head[b] = NULL_LINK;
        shadow_used = 0;
    endfunction

    // Applies one request to the shadow table and returns its response.
    function automatic lookup_rsp_t apply_request(cmd_t cmd, logic [KEY_W-1:0] key,
                                                  logic signed [DATA_W-1:0] price,
                                                  logic signed [DATA_W-1:0] qty);
        lookup_rsp_t       r;
        int                bkt;
        logic [LINK_W-1:0] cur;
        int                steps;
        r   = '{STAT_NOT_FOUND, '0, '0};
        bkt = int'(key % BUCKETS);
        if (cmd == CMD_INSERT)
        begin
            if (shadow_used >= NODES)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                shadow_key[shadow_used]   = key;
                shadow_price[shadow_used] = price;
                shadow_qty[shadow_used]   = qty;
                shadow_next[shadow_used]  = shadow_head[bkt];
                shadow_head[bkt]          = LINK_W'(shadow_used);
                shadow_used++;
                r.status = STAT_INSERTED;
            end
        end
        else
        begin
            cur   = shadow_head[bkt];
            steps = 0;
            while (cur < NODES && steps < NODES)
            begin
                if (shadow_key[cur] == key)
                begin
                    r.status   = STAT_FOUND;
                    r.price    = shadow_price[cur];
                    r.quantity = shadow_qty[cur];
                    break;
                end
                cur = shadow_next[cur];
                steps++;
            end
        end
        return r;
    endfunction

    // Keys: in equal parts crowded into 16 buckets with random upper bits and
    // reused so lookups hit and inserts duplicate; the rest fully random.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int               sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && stored_keys.size() > 0)
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (sel < 8)
            k = {KEY_W'($urandom) & ~KEY_W'(BUCKETS - 1)} |
                KEY_W'($urandom_range(0, 15) * 61);
        else
            k = KEY_W'($urandom);
        return k;
    endfunction

    // Drives one request, waits for its transfer, then records what the
    // response must be. An optional idle burst follows the transfer.
    task automatic send_request(cmd_t cmd, logic [KEY_W-1:0] key,
                                logic signed [DATA_W-1:0] price,
                                logic signed [DATA_W-1:0] qty,
                                bit fixed, lookup_rsp_t fixed_rsp);
        lookup_rsp_t predicted;
        req_if.valid    <= 1'b1;
        req_if.command  <= cmd;
        req_if.key      <= key;
        req_if.price    <= price;
        req_if.quantity <= qty;
        do
            @(posedge clk);
        while (!req_if.ready);
        predicted = apply_request(cmd, key, price, qty);
        if (predicted.status == STAT_INSERTED)
            stored_keys.push_back(key);
        expected_rsps.push_back(fixed ? fixed_rsp : predicted);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_random(int insert_pct);
        cmd_t cmd;
        cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_LOOKUP;
        send_request(cmd, pick_key(), $urandom, $urandom, 1'b0, '0);
    endtask

    // Response side: ready drops in bursts while idling is on.
    initial
    begin : rsp_ready_gen
        forever
        begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (idle_on)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    end

    // Response checker: each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got_rsp = '{status_t'(rsp_if.status), rsp_if.found_price, rsp_if.found_quantity};
            if (expected_rsps.size() == 0)
            begin
                $error("response transfer with nothing expected: status %0d",
                       got_rsp.status);
                fail_count++;
            end
            else
            begin
                want_rsp = expected_rsps.pop_front();
                if (got_rsp.status !== want_rsp.status)
                begin
                    $error("status: expected %0d, actual %0d", want_rsp.status,
                           got_rsp.status);
                    fail_count++;
                end
                if (got_rsp.price !== want_rsp.price)
                begin
                    $error("found_price: expected %0d, actual %0d", want_rsp.price,
                           got_rsp.price);
                    fail_count++;
                end
                if (got_rsp.quantity !== want_rsp.quantity)
                begin
                    $error("found_quantity: expected %0d, actual %0d", want_rsp.quantity,
                           got_rsp.quantity);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        table_row_t row;
        clk             = 1'b0;
        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.command  <= CMD_INSERT;
        req_if.key      <= '0;
        req_if.price    <= '0;
        req_if.quantity <= '0;
        fail_count      = 0;
        idle_on         = 1'b1;
        clear_table();

        // Directed table. Bucket 0 gets keys 0, 1024 and a duplicate of 0;
        // bucket 1023 gets the largest key and then 1023 ahead of it.
        directed_rows = '{
            // empty table: both key extremes miss
            '{CMD_LOOKUP, '0,      32'sd0, 32'sd0, 1'b1, '{STAT_NOT_FOUND, 32'sd0, 32'sd0}},
            '{CMD_LOOKUP, KEY_MAX, D_MAX,  D_MIN,  1'b1, '{STAT_NOT_FOUND, 32'sd0, 32'sd0}},
            // payload extremes stored and read back
            '{CMD_INSERT, '0,      D_MAX,  D_MIN,  1'b1, '{STAT_INSERTED, 32'sd0, 32'sd0}},
            '{CMD_LOOKUP, '0,      32'sd0, 32'sd0, 1'b1, '{STAT_FOUND, D_MAX, D_MIN}},
            '{CMD_INSERT, KEY_MAX, D_MIN,  D_MAX,  1'b1, '{STAT_INSERTED, 32'sd0, 32'sd0}},
            '{CMD_LOOKUP, KEY_MAX, 32'sd0, 32'sd0, 1'b1, '{STAT_FOUND, D_MIN, D_MAX}},
            // collision in bucket 0: old entry found behind the new head
            '{CMD_INSERT, 31'd1024, -32'sd1, 32'sd0, 1'b1, '{STAT_INSERTED, 32'sd0, 32'sd0}},
            '{CMD_LOOKUP, '0,      32'sd0, 32'sd0, 1'b1, '{STAT_FOUND, D_MAX, D_MIN}},
            '{CMD_LOOKUP, 31'd1024, 32'sd0, 32'sd0, 1'b1, '{STAT_FOUND, -32'sd1, 32'sd0}},
            // duplicate key: newest wins
            '{CMD_INSERT, '0,      32'sd5, 32'sd6, 1'b1, '{STAT_INSERTED, 32'sd0, 32'sd0}},
            '{CMD_LOOKUP, '0,      32'sd0, 32'sd0, 1'b1, '{STAT_FOUND, 32'sd5, 32'sd6}},
            // miss after walking a whole chain
            '{CMD_LOOKUP, 31'd2048, 32'sd0, 32'sd0, 1'b1, '{STAT_NOT_FOUND, 32'sd0, 32'sd0}},
            // lookup payload is ignored
            '{CMD_LOOKUP, 31'd1024, 32'sd123, 32'sd456, 1'b1,
              '{STAT_FOUND, -32'sd1, 32'sd0}},
            '{CMD_INSERT, 31'd1023, 32'sd0, -32'sd1, 1'b0, '0},
            '{CMD_LOOKUP, KEY_MAX, 32'sd0, 32'sd0, 1'b0, '0},
            '{CMD_LOOKUP, 31'd1023, D_MIN, D_MAX, 1'b0, '0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_rows[i];
            send_request(row.cmd, row.key, row.price, row.quantity, row.fixed, row.rsp);
        end

        // Random traffic; idling switches on and off in stretches.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 32 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_random(55);
        end

        // Fill the pool, then insert into a full pool and check the full status.
        idle_on = 1'b1;
        while (shadow_used < NODES)
            send_random(90);
        for (int i = 0; i < 8; i++)
            send_request(CMD_INSERT, pick_key(), $urandom, $urandom, 1'b1,
                         '{STAT_FULL, 32'sd0, 32'sd0});

        // Last stretch: back to back, no idling on either side.
        idle_on = 1'b0;
        for (int i = 0; i < 40; i++)
            send_random(20);
        req_if.valid <= 1'b0;

        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
